@@ rtl/ple_pkg.sv @@
// Shared types, codes and controller interface for the positional list engine.
package ple_pkg;

    localparam int unsigned POS_W    = 16;
    localparam int unsigned ELEM_W   = 32;
    localparam int unsigned LENGTH_W = 9;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [POS_W-1:0]         position;
        logic signed [ELEM_W-1:0] new_value;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [ELEM_W-1:0] element;
        logic [LENGTH_W-1:0]      length;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_CAPTURE,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic fetch;
        logic capture;
        logic setup;
        logic shift;
        logic put;
        logic drop;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic ok;
        logic shift_done;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/ple_ctrl.sv @@
// Controller state machine sequencing one list command at a time.
module ple_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ple_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output ple_pkg::t_dp_cmd    o_cmd
);

    ple_pkg::t_state r_state;
    ple_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ple_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ple_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ple_pkg::S_DECODE;
                end
            end
            ple_pkg::S_DECODE: begin
                if (i_status.cmd == ple_pkg::CMD_CLEAR || !i_status.ok) begin
                    n_state = ple_pkg::S_DONE;
                end else if (i_status.cmd == ple_pkg::CMD_INSERT) begin
                    n_state = ple_pkg::S_SHIFT;
                end else begin
                    n_state = ple_pkg::S_FETCH;
                end
            end
            ple_pkg::S_FETCH: begin
                n_state = ple_pkg::S_CAPTURE;
            end
            ple_pkg::S_CAPTURE: begin
                if (i_status.cmd == ple_pkg::CMD_DELETE) begin
                    n_state = ple_pkg::S_SHIFT;
                end else begin
                    n_state = ple_pkg::S_DONE;
                end
            end
            ple_pkg::S_SHIFT: begin
                if (i_status.shift_done) begin
                    if (i_status.cmd == ple_pkg::CMD_INSERT) begin
                        n_state = ple_pkg::S_PUT;
                    end else begin
                        n_state = ple_pkg::S_DONE;
                    end
                end
            end
            ple_pkg::S_PUT: begin
                n_state = ple_pkg::S_DONE;
            end
            ple_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    n_state = ple_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == ple_pkg::S_IDLE);
        o_cmd         = '0;
        o_cmd.load    = (r_state == ple_pkg::S_IDLE) && i_in_valid;
        o_cmd.clear   = (r_state == ple_pkg::S_DECODE) &&
                        (i_status.cmd == ple_pkg::CMD_CLEAR);
        o_cmd.setup   = ((r_state == ple_pkg::S_DECODE) &&
                         (i_status.cmd == ple_pkg::CMD_INSERT) && i_status.ok) ||
                        ((r_state == ple_pkg::S_CAPTURE) &&
                         (i_status.cmd == ple_pkg::CMD_DELETE));
        o_cmd.fetch   = (r_state == ple_pkg::S_FETCH);
        o_cmd.capture = (r_state == ple_pkg::S_CAPTURE);
        o_cmd.shift   = (r_state == ple_pkg::S_SHIFT);
        o_cmd.drop    = (r_state == ple_pkg::S_SHIFT) && i_status.shift_done &&
                        (i_status.cmd == ple_pkg::CMD_DELETE);
        o_cmd.put     = (r_state == ple_pkg::S_PUT);
        o_cmd.finish  = (r_state == ple_pkg::S_DONE) && i_status.out_free;
    end

endmodule

@@ rtl/ple_datapath.sv @@
// Datapath: element memory, shift engine, count, checks and result register.
module ple_datapath #(
    parameter int unsigned CAPACITY    = 256,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ple_pkg::t_dp_cmd    i_cmd,
    input  ple_pkg::t_in        i_in_data,
    input  logic                i_out_ready,
    output ple_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output ple_pkg::t_out       o_out_data
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

    logic signed [VALUE_WIDTH-1:0] r_mem [CAPACITY];

    ple_pkg::t_cmd                 r_cmd;
    ple_pkg::t_status              r_status;
    logic [ple_pkg::POS_W-1:0]     r_pos;
    logic signed [VALUE_WIDTH-1:0] r_val;
    logic [CW-1:0]                 r_count;
    logic signed [ple_pkg::ELEM_W-1:0] r_elem;
    logic [AW-1:0]                 r_ptr;
    logic [CW-1:0]                 r_left;
    logic                          r_dir_up;
    logic                          r_pend;
    logic [AW-1:0]                 r_pend_addr;
    logic signed [VALUE_WIDTH-1:0] r_rdata;
    logic                          r_out_valid;
    ple_pkg::t_out                 r_out;

    logic [PW-1:0]    w_pos_x;
    logic [PW-1:0]    w_cnt_x;
    logic             w_ins_bad;
    logic             w_acc_bad;
    logic             w_full;
    ple_pkg::t_cmd    w_in_cmd;
    ple_pkg::t_status w_load_status;
    logic [AW-1:0]    w_pos_addr;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic signed [VALUE_WIDTH-1:0] w_wr_data;
    logic             w_step;
    logic             w_out_free;

    assign w_in_cmd  = ple_pkg::t_cmd'(i_in_data.cmd);
    assign w_pos_x   = PW'(i_in_data.position);
    assign w_cnt_x   = PW'(r_count);
    assign w_ins_bad = (w_pos_x == '0) || (w_pos_x > w_cnt_x + PW'(1));
    assign w_acc_bad = (w_pos_x == '0) || (w_pos_x > w_cnt_x);
    assign w_full    = (r_count == CW'(CAPACITY));

    always_comb begin
        w_load_status = ple_pkg::ST_OK;
        case (w_in_cmd)
            ple_pkg::CMD_INSERT: begin
                if (w_ins_bad) begin
                    w_load_status = ple_pkg::ST_BAD_POS;
                end else if (w_full) begin
                    w_load_status = ple_pkg::ST_FULL;
                end
            end
            ple_pkg::CMD_DELETE, ple_pkg::CMD_READ: begin
                if (w_acc_bad) begin
                    w_load_status = ple_pkg::ST_BAD_POS;
                end
            end
            default: begin
                w_load_status = ple_pkg::ST_OK;
            end
        endcase
    end

    assign w_pos_addr = AW'(r_pos - ple_pkg::POS_W'(1));
    assign w_step     = i_cmd.shift && (r_left != '0);
    assign w_rd_en    = i_cmd.fetch || w_step;
    assign w_rd_addr  = i_cmd.fetch ? w_pos_addr : r_ptr;
    assign w_wr_en    = i_cmd.put || (i_cmd.shift && r_pend);
    assign w_wr_addr  = i_cmd.put ? w_pos_addr : r_pend_addr;
    assign w_wr_data  = i_cmd.put ? r_val : r_rdata;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= w_in_cmd;
            r_status <= w_load_status;
            r_pos    <= i_in_data.position;
            r_val    <= VALUE_WIDTH'(i_in_data.new_value);
            r_elem   <= '0;
        end
        if (i_cmd.capture) begin
            r_elem <= ple_pkg::ELEM_W'(r_rdata);
        end
        if (i_cmd.setup) begin
            if (r_cmd == ple_pkg::CMD_INSERT) begin
                r_ptr    <= AW'(r_count - CW'(1));
                r_dir_up <= 1'b1;
            end else begin
                r_ptr    <= AW'(r_pos);
                r_dir_up <= 1'b0;
            end
        end else if (w_step) begin
            r_pend_addr <= r_dir_up ? r_ptr + AW'(1) : r_ptr - AW'(1);
            r_ptr       <= r_dir_up ? r_ptr - AW'(1) : r_ptr + AW'(1);
        end
        if (i_cmd.finish) begin
            r_out.status  <= r_status;
            r_out.element <= r_elem;
            r_out.length  <= ple_pkg::LENGTH_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.drop) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.setup) begin
                r_pend <= 1'b0;
                if (r_cmd == ple_pkg::CMD_INSERT) begin
                    r_left <= CW'(w_cnt_x + PW'(1) - PW'(r_pos));
                end else begin
                    r_left <= CW'(w_cnt_x - PW'(r_pos));
                end
            end else if (i_cmd.shift) begin
                r_pend <= w_step;
                if (w_step) begin
                    r_left <= r_left - CW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.cmd        = r_cmd;
    assign o_status.ok         = (r_status == ple_pkg::ST_OK);
    assign o_status.shift_done = (r_left == '0) && !r_pend;
    assign o_status.out_free   = w_out_free;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;

endmodule

@@ rtl/positional_list_engine_top.sv @@
// Top level of the positional list engine: controller plus datapath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------
//  command  | i_in_valid / o_in_ready   | i_in_data  (ple_pkg::t_in)
//  result   | o_out_valid / i_out_ready | o_out_data (ple_pkg::t_out)
//
// One command at a time; a new transfer is taken once the previous result is
// registered. Clear and rejected commands go from decode straight to done;
// read fetches and captures the element; delete captures it, then shifts;
// insert shifts, then writes; the shift engine moves one memory element per cycle.
// Reset empties the list; memory contents are not cleared. A stalled result
// holds in the output register while the next command runs up to its handover.
module positional_list_engine_top #(
    parameter int unsigned CAPACITY    = 256,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ple_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ple_pkg::t_out o_out_data
);

    ple_pkg::t_dp_cmd    w_cmd;
    ple_pkg::t_dp_status w_status;

    ple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    ple_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/ple_checker.sv @@
// Port-level assertions for the positional list engine, bound to the top level.
module ple_checker #(
    parameter int unsigned CAPACITY = 256
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input ple_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ple_pkg::t_out o_out_data
);

    localparam logic [ple_pkg::LENGTH_W-1:0] FULL_LEN = ple_pkg::LENGTH_W'(CAPACITY);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer taken while busy");

    a_elem_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ple_pkg::ST_OK) |->
            (o_out_data.element == '0))
        else $error("nonzero element on failed command");

    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ple_pkg::ST_FULL) |->
            (o_out_data.length == FULL_LEN))
        else $error("full status with list not full");

endmodule

bind positional_list_engine_top ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

@@ sim/positional_list_engine_top_test.sv @@
// Self-checking testbench for the positional list engine: directed table, full-list probe, then random episodes.
module positional_list_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int unsigned LIST_CAP     = 256;
    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam longint      TIMEOUT_NS   = 64'd10_000_000;
    localparam int unsigned SCRIPT_ROWS  = 24;

    typedef enum logic [1:0] {
        EP_GROW,
        EP_SHRINK,
        EP_MIXED,
        EP_NOISE
    } t_episode;

    typedef struct packed {
        t_in  item;
        logic has_want;
        t_out want;
    } t_script_row;

    localparam t_script_row SCRIPT [SCRIPT_ROWS] = '{
        '{'{CMD_READ,   16'd1,     32'sd0},        1'b1, '{ST_BAD_POS, 32'sd0,         9'd0}},
        '{'{CMD_DELETE, 16'd0,     32'sd0},        1'b1, '{ST_BAD_POS, 32'sd0,         9'd0}},
        '{'{CMD_INSERT, 16'd0,     32'sd1},        1'b1, '{ST_BAD_POS, 32'sd0,         9'd0}},
        '{'{CMD_INSERT, 16'd2,     32'sd1},        1'b1, '{ST_BAD_POS, 32'sd0,         9'd0}},
        '{'{CMD_INSERT, 16'd1,     32'h7FFF_FFFF}, 1'b1, '{ST_OK,      32'sd0,         9'd1}},
        '{'{CMD_INSERT, 16'd1,     32'h8000_0000}, 1'b1, '{ST_OK,      32'sd0,         9'd2}},
        '{'{CMD_INSERT, 16'd3,     32'hFFFF_FFFF}, 1'b1, '{ST_OK,      32'sd0,         9'd3}},
        '{'{CMD_READ,   16'd1,     32'sd0},        1'b1, '{ST_OK,      32'h8000_0000,  9'd3}},
        '{'{CMD_READ,   16'd3,     32'sd0},        1'b1, '{ST_OK,      32'hFFFF_FFFF,  9'd3}},
        '{'{CMD_READ,   16'd4,     32'sd0},        1'b1, '{ST_BAD_POS, 32'sd0,         9'd3}},
        '{'{CMD_DELETE, 16'hFFFF,  32'sd0},        1'b1, '{ST_BAD_POS, 32'sd0,         9'd3}},
        '{'{CMD_INSERT, 16'hFFFF,  32'sd0},        1'b1, '{ST_BAD_POS, 32'sd0,         9'd3}},
        '{'{CMD_INSERT, 16'd2,     32'h1234_5678}, 1'b0, '0},
        '{'{CMD_READ,   16'd2,     32'sd0},        1'b0, '0},
        '{'{CMD_DELETE, 16'd1,     32'sd0},        1'b0, '0},
        '{'{CMD_DELETE, 16'd3,     32'sd0},        1'b0, '0},
        '{'{CMD_CLEAR,  16'hFFFF,  32'hA5A5_A5A5}, 1'b1, '{ST_OK,      32'sd0,         9'd0}},
        '{'{CMD_DELETE, 16'd1,     32'sd0},        1'b1, '{ST_BAD_POS, 32'sd0,         9'd0}},
        '{'{CMD_INSERT, 16'd1,     32'sd0},        1'b1, '{ST_OK,      32'sd0,         9'd1}},
        '{'{CMD_READ,   16'd1,     32'sd0},        1'b0, '0},
        '{'{CMD_INSERT, 16'd1,     32'h5555_5555}, 1'b0, '0},
        '{'{CMD_INSERT, 16'd3,     32'hAAAA_AAAA}, 1'b0, '0},
        '{'{CMD_DELETE, 16'd2,     32'sd0},        1'b0, '0},
        '{'{CMD_CLEAR,  16'd0,     32'sd0},        1'b1, '{ST_OK,      32'sd0,         9'd0}}
    };

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data  = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    // list contents as the block should hold them
    logic signed [ELEM_W-1:0] list_words [LIST_CAP];
    int unsigned              list_len = 0;

    t_out        pending_results [$];
    bit          steady          = 1'b0;
    int unsigned commands_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned full_hits       = 0;
    int unsigned bad_pos_hits    = 0;
    int unsigned peak_len        = 0;

    positional_list_engine_top #(
        .CAPACITY    (LIST_CAP),
        .VALUE_WIDTH (ELEM_W)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic t_out apply_list_command(t_in item);
        t_out        res;
        int unsigned pos;
        res = '0;
        pos = item.position;
        case (t_cmd'(item.cmd))
            CMD_CLEAR: begin
                list_len = 0;
            end
            CMD_INSERT: begin
                if (pos == 0 || pos > list_len + 1) begin
                    res.status = ST_BAD_POS;
                end else if (list_len >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = list_len; k >= pos; k--) list_words[k] = list_words[k-1];
                    list_words[pos-1] = item.new_value;
                    list_len++;
                end
            end
            default: begin
                if (pos == 0 || pos > list_len) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res.element = list_words[pos-1];
                    if (t_cmd'(item.cmd) == CMD_DELETE) begin
                        for (int k = pos; k < list_len; k++) list_words[k-1] = list_words[k];
                        list_len--;
                    end
                end
            end
        endcase
        res.length = list_len[LENGTH_W-1:0];
        return res;
    endfunction

    function automatic logic [ELEM_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] valid_position(int unsigned hi);
        if (hi == 0) return 16'd1;
        case ($urandom_range(0, 5))
            0: return 16'd1;
            1: return POS_W'(hi);
            default: return POS_W'($urandom_range(1, hi));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] noise_position();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return POS_W'(list_len);
            2: return POS_W'(list_len + 1);
            3: return POS_W'(list_len + 2);
            4: return '1;
            default: return POS_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h", results_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_command(t_in item, logic has_want, t_out want);
        t_out        predicted;
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = apply_list_command(item);
        pending_results.push_back(has_want ? want : predicted);
        commands_sent++;
        if (predicted.status == ST_FULL) full_hits++;
        if (predicted.status == ST_BAD_POS) bad_pos_hits++;
        if (list_len > peak_len) peak_len = list_len;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic run_episode(t_episode mode, int unsigned count);
        t_in         item;
        int unsigned roll;
        repeat (count) begin
            roll           = $urandom_range(0, 99);
            item.new_value = draw_value();
            item.cmd       = CMD_READ;
            item.position  = valid_position(list_len);
            case (mode)
                EP_GROW: begin
                    if (roll < 85) begin
                        item.cmd      = CMD_INSERT;
                        item.position = valid_position(list_len + 1);
                    end
                end
                EP_SHRINK: begin
                    if (roll < 80) item.cmd = CMD_DELETE;
                end
                EP_MIXED: begin
                    if (roll < 35) begin
                        item.cmd      = CMD_INSERT;
                        item.position = valid_position(list_len + 1);
                    end else if (roll < 65) begin
                        item.cmd = CMD_DELETE;
                    end else if (roll >= 97) begin
                        item.cmd = CMD_CLEAR;
                    end
                end
                default: begin
                    item.cmd      = 2'($urandom_range(0, 3));
                    item.position = noise_position();
                end
            endcase
            send_command(item, 1'b0, '0);
        end
    endtask

    // result side: stall, then take one transfer and check it
    initial begin
        int unsigned stall;
        t_out        want;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(out_data.status), '0);
            end else begin
                want = pending_results.pop_front();
                if (out_data.status != want.status)
                    report_mismatch("status", 32'(out_data.status), 32'(want.status));
                if (out_data.element != want.element)
                    report_mismatch("element", out_data.element, want.element);
                if (out_data.length != want.length)
                    report_mismatch("length", 32'(out_data.length), 32'(want.length));
            end
            results_checked++;
        end
    end

    initial begin
        int unsigned roll;
        t_episode    mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++)
            send_command(SCRIPT[r].item, SCRIPT[r].has_want, SCRIPT[r].want);
        wait_drained();

        // fill to capacity, then probe the full list
        while (list_len < LIST_CAP) run_episode(EP_GROW, 1);
        send_command('{CMD_INSERT, valid_position(list_len + 1), draw_value()}, 1'b0, '0);
        send_command('{CMD_INSERT, POS_W'(list_len + 1), draw_value()}, 1'b0, '0);
        send_command('{CMD_INSERT, POS_W'(list_len + 2), draw_value()}, 1'b0, '0);
        send_command('{CMD_READ, POS_W'(list_len), draw_value()}, 1'b0, '0);
        send_command('{CMD_DELETE, POS_W'(list_len), draw_value()}, 1'b0, '0);
        send_command('{CMD_DELETE, 16'd1, draw_value()}, 1'b0, '0);
        send_command('{CMD_INSERT, 16'd1, draw_value()}, 1'b0, '0);
        send_command('{CMD_INSERT, POS_W'(list_len + 1), draw_value()}, 1'b0, '0);
        wait_drained();

        while (commands_sent < SCRIPT_ROWS + RANDOM_ITEMS) begin
            roll   = $urandom_range(0, 99);
            mode   = roll < 40 ? EP_MIXED : roll < 60 ? EP_SHRINK : roll < 85 ? EP_GROW : EP_NOISE;
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) wait_drained();
            run_episode(mode, $urandom_range(10, 50));
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d commands, %0d results checked, %0d mismatches",
                 commands_sent, results_checked, mismatch_count);
        $display("summary: %0d full-list rejects, %0d bad positions, peak length %0d",
                 full_hits, bad_pos_hits, peak_len);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ple_pkg.sv
rtl/ple_ctrl.sv
rtl/ple_datapath.sv
rtl/positional_list_engine_top.sv
rtl/ple_checker.sv
sim/positional_list_engine_top_test.sv
